FILE: src/lovc_pkg.sv
// Shared constants, types and register codes of the layer overhang classifier.
package lovc_pkg;

  localparam int SEGS_PER_LAYER = 1024;
  localparam int BANK_AW        = $clog2(SEGS_PER_LAYER);
  localparam int RAM_AW         = BANK_AW + 1;
  localparam int RAM_DEPTH      = 2 * SEGS_PER_LAYER;
  localparam int CNT_W          = $clog2(SEGS_PER_LAYER + 1);

  localparam int CRD_W  = 21;
  localparam int PT_W   = CRD_W + 1;
  localparam int PNT_W  = 2 * CRD_W;
  localparam int Z_W    = 20;
  localparam int A_W    = Z_W + 1;
  localparam int TAG_W  = 24;
  localparam int MRG_W  = 10;
  localparam int BF_W   = 7;
  localparam int SEV_W  = 2;
  localparam int DSQ_W  = 43;

  localparam int DIF_W  = 24;
  localparam int MUL_W  = 30;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = 49;
  localparam int MAG_W  = 46;
  localparam int HALF_W = MAG_W / 2;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int QUO_W  = 54;
  localparam int REM_W  = 48;
  localparam int KEY_W  = 56;
  localparam int CMP_W  = 58;
  localparam int STEP_W = 4;
  localparam int DCNT_W = $clog2(QUO_W);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [MRG_W-1:0] MARGIN_RST  = MRG_W'(100);
  localparam logic [MRG_W-1:0] MIN_OVH_RST = MRG_W'(100);
  localparam logic [BF_W-1:0]  BRIDGE_RST  = BF_W'(24);

  localparam logic [SEV_W-1:0] SEV_MINOR    = 2'd0;
  localparam logic [SEV_W-1:0] SEV_MODERATE = 2'd1;
  localparam logic [SEV_W-1:0] SEV_SEVERE   = 2'd2;

  typedef enum logic [1:0] {
    REG_MARGIN  = 2'd0,
    REG_MIN_OVH = 2'd1,
    REG_BRIDGE  = 2'd2
  } lovc_reg_t;

  typedef struct packed {
    logic signed [PT_W-1:0] s_x;
    logic signed [PT_W-1:0] s_y;
    logic signed [PT_W-1:0] e_x;
    logic signed [PT_W-1:0] e_y;
    logic signed [PT_W-1:0] m_x;
    logic signed [PT_W-1:0] m_y;
    logic                   arc;
    logic [CNT_W-1:0]       prev_cnt;
    logic                   pbank;
    logic                   z_up;
    logic [Z_W-1:0]         height;
    logic [TAG_W-1:0]       tag;
    logic                   full;
  } lovc_job_t;

endpackage

FILE: src/layer_overhang_classifier.sv
// Top level of the layer overhang classifier with its configuration registers.
// For each item, the back end measures the distance from each of its three points to
// every segment stored for the layer below; a point whose nearest spot lies inside a
// stored segment rather than at one of its ends takes a square and a division more.
// One shared 30-by-30 multiplier runs each point-to-segment distance as a sequence of
// products, and a divider gives one quotient bit per cycle. Items of the first layer
// skip the search.
// An item that starts a new layer waits until all items of the old layer are done.
module layer_overhang_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lovc_pkg::PADDR_W-1:0]        paddr,
  input  logic [lovc_pkg::PDATA_W-1:0]        pwdata,
  output logic [lovc_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lovc_pkg::CRD_W-1:0]   in_x_start,
  input  logic signed [lovc_pkg::CRD_W-1:0]   in_y_start,
  input  logic signed [lovc_pkg::CRD_W-1:0]   in_x_end,
  input  logic signed [lovc_pkg::CRD_W-1:0]   in_y_end,
  input  logic                                in_is_arc,
  input  logic signed [lovc_pkg::CRD_W-1:0]   in_mid_x,
  input  logic signed [lovc_pkg::CRD_W-1:0]   in_mid_y,
  input  logic [lovc_pkg::Z_W-1:0]            in_layer_z,
  input  logic [lovc_pkg::TAG_W-1:0]          in_segment_tag,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_is_event,
  output logic                                out_is_bridge,
  output logic [lovc_pkg::SEV_W-1:0]          out_severity,
  output logic [lovc_pkg::DSQ_W-1:0]          out_max_dist_sq,
  output logic [lovc_pkg::Z_W-1:0]            out_layer_height,
  output logic [lovc_pkg::TAG_W-1:0]          out_tag_out,
  output logic                                out_store_full
);
  import lovc_pkg::*;

  logic [MRG_W-1:0]  margin_r, min_ovh_r;
  logic [BF_W-1:0]   bfac_r;
  logic              cfg_wr;
  lovc_reg_t         cfg_sel;

  logic              back_idle, fifo_full, fifo_empty, push, pop;
  lovc_job_t         fjob, bjob;
  logic              st_we;
  logic [RAM_AW-1:0] st_waddr, st_raddr;
  logic [PNT_W-1:0]  st_start_wdata, st_end_wdata, st_start_rdata, st_end_rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = lovc_reg_t'(paddr[3:2]);

  always_comb begin
    unique case (cfg_sel)
      REG_MARGIN:  prdata = PDATA_W'(margin_r);
      REG_MIN_OVH: prdata = PDATA_W'(min_ovh_r);
      REG_BRIDGE:  prdata = PDATA_W'(bfac_r);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r  <= MARGIN_RST;
      min_ovh_r <= MIN_OVH_RST;
      bfac_r    <= BRIDGE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_MARGIN:  margin_r  <= pwdata[MRG_W-1:0];
        REG_MIN_OVH: min_ovh_r <= pwdata[MRG_W-1:0];
        REG_BRIDGE:  bfac_r    <= pwdata[BF_W-1:0];
        default: ;
      endcase
    end
  end

  lovc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_is_arc      (in_is_arc),
    .in_mid_x       (in_mid_x),
    .in_mid_y       (in_mid_y),
    .in_layer_z     (in_layer_z),
    .in_segment_tag (in_segment_tag),
    .back_idle      (back_idle),
    .fifo_full      (fifo_full),
    .fifo_empty     (fifo_empty),
    .push           (push),
    .job            (fjob),
    .st_we          (st_we),
    .st_waddr       (st_waddr),
    .st_start_wdata (st_start_wdata),
    .st_end_wdata   (st_end_wdata)
  );

  lovc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (fjob),
    .pop   (pop),
    .dout  (bjob),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  lovc_ram #(.WIDTH(PNT_W), .DEPTH(RAM_DEPTH)) u_start_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_start_wdata),
    .raddr (st_raddr),
    .rdata (st_start_rdata)
  );

  lovc_ram #(.WIDTH(PNT_W), .DEPTH(RAM_DEPTH)) u_end_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_end_wdata),
    .raddr (st_raddr),
    .rdata (st_end_rdata)
  );

  lovc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fifo_empty       (fifo_empty),
    .job              (bjob),
    .pop              (pop),
    .back_idle        (back_idle),
    .margin           (margin_r),
    .min_ovh          (min_ovh_r),
    .bfac             (bfac_r),
    .st_raddr         (st_raddr),
    .st_start_rdata   (st_start_rdata),
    .st_end_rdata     (st_end_rdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_event     (out_is_event),
    .out_is_bridge    (out_is_bridge),
    .out_severity     (out_severity),
    .out_max_dist_sq  (out_max_dist_sq),
    .out_layer_height (out_layer_height),
    .out_tag_out      (out_tag_out),
    .out_store_full   (out_store_full)
  );

endmodule

FILE: src/lovc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lovc_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/lovc_fifo.sv
// Short job queue between the front and the back of the classifier.
module lovc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lovc_pkg::lovc_job_t din,
  input  logic                pop,
  output lovc_pkg::lovc_job_t dout,
  output logic                full,
  output logic                empty
);
  import lovc_pkg::*;

  lovc_job_t            entry_r [FIFO_DEPTH];
  logic [FIFO_PW-1:0]   wp_r;
  logic [FIFO_PW-1:0]   rp_r;
  logic [FIFO_CW-1:0]   cnt_r;

  assign full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        entry_r[wp_r] <= din;
        wp_r <= (wp_r == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: src/lovc_front.sv
// Front of the classifier: accepts items, tracks layers and banks, and stores segments.
module lovc_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lovc_pkg::CRD_W-1:0]   in_x_start,
  input  logic signed [lovc_pkg::CRD_W-1:0]   in_y_start,
  input  logic signed [lovc_pkg::CRD_W-1:0]   in_x_end,
  input  logic signed [lovc_pkg::CRD_W-1:0]   in_y_end,
  input  logic                                in_is_arc,
  input  logic signed [lovc_pkg::CRD_W-1:0]   in_mid_x,
  input  logic signed [lovc_pkg::CRD_W-1:0]   in_mid_y,
  input  logic [lovc_pkg::Z_W-1:0]            in_layer_z,
  input  logic [lovc_pkg::TAG_W-1:0]          in_segment_tag,
  input  logic                                back_idle,
  input  logic                                fifo_full,
  input  logic                                fifo_empty,
  output logic                                push,
  output lovc_pkg::lovc_job_t                 job,
  output logic                                st_we,
  output logic [lovc_pkg::RAM_AW-1:0]         st_waddr,
  output logic [lovc_pkg::PNT_W-1:0]          st_start_wdata,
  output logic [lovc_pkg::PNT_W-1:0]          st_end_wdata
);
  import lovc_pkg::*;

  logic [CNT_W-1:0] cur_cnt_r, prev_cnt_r;
  logic [Z_W-1:0]   cur_z_r, prev_z_r;
  logic             bank_r, open_r, ovf_r;

  logic             chg, acc, room;
  logic [CNT_W-1:0] cnt_nxt, prev_cnt_nxt;
  logic [Z_W-1:0]   prev_z_nxt;
  logic             bank_nxt, ovf_nxt;

  always_comb begin
    chg      = open_r && (in_layer_z != cur_z_r);
    in_ready = !fifo_full && (!chg || (fifo_empty && back_idle));
    acc      = in_valid && in_ready;

    cnt_nxt      = cur_cnt_r;
    bank_nxt     = bank_r;
    prev_cnt_nxt = prev_cnt_r;
    prev_z_nxt   = prev_z_r;
    ovf_nxt      = ovf_r;
    if (!open_r) begin
      cnt_nxt = '0;
    end else if (chg) begin
      cnt_nxt      = '0;
      bank_nxt     = ~bank_r;
      prev_cnt_nxt = cur_cnt_r;
      prev_z_nxt   = cur_z_r;
      ovf_nxt      = 1'b0;
    end
    room = (cnt_nxt < CNT_W'(SEGS_PER_LAYER));

    push           = acc;
    st_we          = acc && room;
    st_waddr       = {bank_nxt, cnt_nxt[BANK_AW-1:0]};
    st_start_wdata = {in_y_start, in_x_start};
    st_end_wdata   = {in_y_end, in_x_end};

    job.s_x      = {in_x_start, 1'b0};
    job.s_y      = {in_y_start, 1'b0};
    job.e_x      = {in_x_end, 1'b0};
    job.e_y      = {in_y_end, 1'b0};
    job.m_x      = in_is_arc ? {in_mid_x, 1'b0}
                             : {in_x_start[CRD_W-1], in_x_start} + {in_x_end[CRD_W-1], in_x_end};
    job.m_y      = in_is_arc ? {in_mid_y, 1'b0}
                             : {in_y_start[CRD_W-1], in_y_start} + {in_y_end[CRD_W-1], in_y_end};
    job.arc      = in_is_arc;
    job.prev_cnt = prev_cnt_nxt;
    job.pbank    = ~bank_nxt;
    job.z_up     = (in_layer_z > prev_z_nxt);
    job.height   = in_layer_z - prev_z_nxt;
    job.tag      = in_segment_tag;
    job.full     = ovf_nxt || !room;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cnt_r  <= '0;
      prev_cnt_r <= '0;
      cur_z_r    <= '0;
      prev_z_r   <= '0;
      bank_r     <= 1'b0;
      open_r     <= 1'b0;
      ovf_r      <= 1'b0;
    end else if (acc) begin
      open_r     <= 1'b1;
      cur_z_r    <= in_layer_z;
      bank_r     <= bank_nxt;
      prev_cnt_r <= prev_cnt_nxt;
      prev_z_r   <= prev_z_nxt;
      cur_cnt_r  <= room ? cnt_nxt + 1'b1 : cnt_nxt;
      ovf_r      <= ovf_nxt || !room;
    end
  end

endmodule

FILE: src/lovc_back.sv
// Back of the classifier: nearest-distance search over the layer below and classification.
module lovc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fifo_empty,
  input  lovc_pkg::lovc_job_t               job,
  output logic                              pop,
  output logic                              back_idle,
  input  logic [lovc_pkg::MRG_W-1:0]        margin,
  input  logic [lovc_pkg::MRG_W-1:0]        min_ovh,
  input  logic [lovc_pkg::BF_W-1:0]         bfac,
  output logic [lovc_pkg::RAM_AW-1:0]       st_raddr,
  input  logic [lovc_pkg::PNT_W-1:0]        st_start_rdata,
  input  logic [lovc_pkg::PNT_W-1:0]        st_end_rdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_is_event,
  output logic                              out_is_bridge,
  output logic [lovc_pkg::SEV_W-1:0]        out_severity,
  output logic [lovc_pkg::DSQ_W-1:0]        out_max_dist_sq,
  output logic [lovc_pkg::Z_W-1:0]          out_layer_height,
  output logic [lovc_pkg::TAG_W-1:0]        out_tag_out,
  output logic                              out_store_full
);
  import lovc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_LOAD, ST_DIST, ST_PICK, ST_SQR, ST_DIV, ST_NEXT, ST_CLASS, ST_DONE
  } state_t;

  state_t                    state_r;
  lovc_job_t                 job_r;
  logic [CNT_W-1:0]          idx_r;
  logic [1:0]                pt_r;
  logic [STEP_W-1:0]         step_r;
  logic signed [PT_W-1:0]    sx_r, sy_r, ex_r, ey_r;
  logic signed [SUM_W-1:0]   t0_r, c1_r, c2_r, dw_r, dd_r, cross_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [SQ_W-1:0]           msq_r;
  logic [REM_W-1:0]          rem_r;
  logic [QUO_W-1:0]          nlo_r, quo_r;
  logic [DCNT_W-1:0]         dcnt_r;
  logic [KEY_W-1:0]          best_r [3];
  logic [PROD_W-1:0]         aa_r, tt_r, hh_r, bb_r;
  logic                      out_valid_r, ev_r, br_r, full_r;
  logic [SEV_W-1:0]          sev_r;
  logic [DSQ_W-1:0]          dsq_r;
  logic [Z_W-1:0]            height_r;
  logic [TAG_W-1:0]          tag_r;

  logic signed [PT_W-1:0]    px, py;
  logic signed [DIF_W-1:0]   vx, vy, wx, wy, dx, dy;
  logic signed [MUL_W-1:0]   mop_a, mop_b;
  logic signed [PROD_W-1:0]  prod_c;
  logic signed [SUM_W-1:0]   p_s;
  logic [SUM_W-1:0]          cross_abs;
  logic [HALF_W-1:0]         mag_hi, mag_lo;
  logic                      pick_direct;
  logic [KEY_W-1:0]          pick_key, div_key;
  logic [SQ_W-1:0]           msq_fin;
  logic [REM_W-1:0]          remsh, c2u, rem_n;
  logic                      qbit;
  logic [QUO_W-1:0]          quo_n;
  logic [A_W-1:0]            a_c, t_c;
  logic [KEY_W-1:0]          kmax;
  logic [CMP_W-1:0]          kmax_w, ks_w, ke_w, km_w, lim_a, lim_t, h2, h3, brl;
  logic                      ev_c, br_c;
  logic [SEV_W-1:0]          sev_c;
  logic [DSQ_W-1:0]          dsq_c;
  logic [Z_W-1:0]            height_c;

  assign pop       = (state_r == ST_IDLE) && !fifo_empty;
  assign back_idle = (state_r == ST_IDLE);
  assign st_raddr  = {job_r.pbank, idx_r[BANK_AW-1:0]};

  always_comb begin
    case (pt_r)
      2'd0:    begin px = job_r.s_x; py = job_r.s_y; end
      2'd1:    begin px = job_r.e_x; py = job_r.e_y; end
      default: begin px = job_r.m_x; py = job_r.m_y; end
    endcase
    vx = DIF_W'(ex_r) - DIF_W'(sx_r);
    vy = DIF_W'(ey_r) - DIF_W'(sy_r);
    wx = DIF_W'(px) - DIF_W'(sx_r);
    wy = DIF_W'(py) - DIF_W'(sy_r);
    dx = DIF_W'(px) - DIF_W'(ex_r);
    dy = DIF_W'(py) - DIF_W'(ey_r);

    cross_abs = cross_r[SUM_W-1] ? SUM_W'(-cross_r) : SUM_W'(cross_r);
    mag_hi    = cross_abs[MAG_W-1:HALF_W];
    mag_lo    = cross_abs[HALF_W-1:0];

    a_c = A_W'(job_r.height) + A_W'(margin);
    t_c = (a_c > A_W'(min_ovh)) ? a_c : A_W'(min_ovh);
  end

  always_comb begin
    mop_a = '0;
    mop_b = '0;
    case (state_r)
      ST_DIST: begin
        case (step_r)
          4'd0:    begin mop_a = MUL_W'(vx); mop_b = MUL_W'(wx); end
          4'd1:    begin mop_a = MUL_W'(vy); mop_b = MUL_W'(wy); end
          4'd2:    begin mop_a = MUL_W'(wx); mop_b = MUL_W'(wx); end
          4'd3:    begin mop_a = MUL_W'(wy); mop_b = MUL_W'(wy); end
          4'd4:    begin mop_a = MUL_W'(vx); mop_b = MUL_W'(vx); end
          4'd5:    begin mop_a = MUL_W'(vy); mop_b = MUL_W'(vy); end
          4'd6:    begin mop_a = MUL_W'(dx); mop_b = MUL_W'(dx); end
          4'd7:    begin mop_a = MUL_W'(dy); mop_b = MUL_W'(dy); end
          4'd8:    begin mop_a = MUL_W'(vx); mop_b = MUL_W'(wy); end
          4'd9:    begin mop_a = MUL_W'(vy); mop_b = MUL_W'(wx); end
          default: begin mop_a = '0; mop_b = '0; end
        endcase
      end
      ST_SQR: begin
        case (step_r)
          4'd0:    begin
            mop_a = $signed({(MUL_W - HALF_W)'(0), mag_hi});
            mop_b = $signed({(MUL_W - HALF_W)'(0), mag_hi});
          end
          4'd1:    begin
            mop_a = $signed({(MUL_W - HALF_W)'(0), mag_hi});
            mop_b = $signed({(MUL_W - HALF_W)'(0), mag_lo});
          end
          4'd2:    begin
            mop_a = $signed({(MUL_W - HALF_W)'(0), mag_lo});
            mop_b = $signed({(MUL_W - HALF_W)'(0), mag_lo});
          end
          default: begin mop_a = '0; mop_b = '0; end
        endcase
      end
      ST_CLASS: begin
        case (step_r)
          4'd0:    begin
            mop_a = $signed(MUL_W'(a_c)); mop_b = $signed(MUL_W'(a_c));
          end
          4'd1:    begin
            mop_a = $signed(MUL_W'(t_c)); mop_b = $signed(MUL_W'(t_c));
          end
          4'd2:    begin
            mop_a = $signed(MUL_W'(job_r.height)); mop_b = $signed(MUL_W'(job_r.height));
          end
          4'd3:    begin
            mop_a = $signed(MUL_W'(bfac)); mop_b = $signed(MUL_W'(a_c));
          end
          4'd4:    begin
            mop_a = prod_r[MUL_W-1:0]; mop_b = prod_r[MUL_W-1:0];
          end
          default: begin mop_a = '0; mop_b = '0; end
        endcase
      end
      default: begin mop_a = '0; mop_b = '0; end
    endcase
    prod_c = mop_a * mop_b;
    p_s    = prod_r[SUM_W-1:0];
  end

  always_comb begin
    pick_direct = c1_r[SUM_W-1] || (c1_r == '0) || (c2_r <= c1_r);
    if (c1_r[SUM_W-1] || (c1_r == '0)) begin
      pick_key = KEY_W'({dw_r[SUM_W-2:0], 7'b0});
    end else begin
      pick_key = KEY_W'({dd_r[SUM_W-2:0], 7'b0});
    end

    msq_fin = msq_r + SQ_W'(prod_r[2*HALF_W-1:0]);

    remsh = {rem_r[REM_W-2:0], nlo_r[QUO_W-1]};
    c2u   = c2_r[REM_W-1:0];
    qbit  = (remsh >= c2u);
    rem_n = qbit ? remsh - c2u : remsh;
    quo_n = {quo_r[QUO_W-2:0], qbit};
    div_key = KEY_W'({quo_n, rem_n != '0});
  end

  always_comb begin
    kmax = best_r[0];
    if (best_r[1] > kmax) kmax = best_r[1];
    if (best_r[2] > kmax) kmax = best_r[2];
    kmax_w = CMP_W'(kmax);
    ks_w   = CMP_W'(best_r[0]);
    ke_w   = CMP_W'(best_r[1]);
    km_w   = CMP_W'(best_r[2]);
    lim_a  = CMP_W'(aa_r) << 9;
    lim_t  = CMP_W'(tt_r) << 9;
    h2     = CMP_W'(hh_r) << 9;
    h3     = h2 + (h2 << 1);
    brl    = CMP_W'(bb_r) << 1;

    ev_c     = 1'b0;
    br_c     = 1'b0;
    sev_c    = SEV_MINOR;
    dsq_c    = '0;
    height_c = '0;
    if (job_r.prev_cnt != '0) begin
      dsq_c = kmax[DSQ_W+8:9];
      if (job_r.z_up) begin
        height_c = job_r.height;
        if (kmax_w > lim_t) begin
          ev_c = 1'b1;
          br_c = !job_r.arc && (ks_w <= lim_a) && (ke_w <= lim_a) && (km_w > brl);
          if (kmax_w >= h3) begin
            sev_c = SEV_SEVERE;
          end else if (kmax_w >= h2) begin
            sev_c = SEV_MODERATE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      prod_r <= prod_c;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!fifo_empty) begin
            job_r     <= job;
            idx_r     <= '0;
            pt_r      <= 2'd0;
            best_r[0] <= '1;
            best_r[1] <= '1;
            best_r[2] <= '1;
            state_r   <= (job.prev_cnt == '0) ? ST_DONE : ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          sx_r    <= {st_start_rdata[CRD_W-1:0], 1'b0};
          sy_r    <= {st_start_rdata[PNT_W-1:CRD_W], 1'b0};
          ex_r    <= {st_end_rdata[CRD_W-1:0], 1'b0};
          ey_r    <= {st_end_rdata[PNT_W-1:CRD_W], 1'b0};
          pt_r    <= 2'd0;
          step_r  <= '0;
          state_r <= ST_DIST;
        end
        ST_DIST: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd9: t0_r <= p_s;
            4'd2:    c1_r <= t0_r + p_s;
            4'd4:    dw_r <= t0_r + p_s;
            4'd6:    c2_r <= t0_r + p_s;
            4'd8:    dd_r <= t0_r + p_s;
            4'd10: begin
              cross_r <= t0_r - p_s;
              state_r <= ST_PICK;
            end
            default: ;
          endcase
        end
        ST_PICK: begin
          step_r <= '0;
          if (pick_direct) begin
            if (pick_key < best_r[pt_r]) begin
              best_r[pt_r] <= pick_key;
            end
            state_r <= ST_NEXT;
          end else begin
            state_r <= ST_SQR;
          end
        end
        ST_SQR: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            4'd1: msq_r <= {prod_r[2*HALF_W-1:0], (2*HALF_W)'(0)};
            4'd2: msq_r <= msq_r + SQ_W'({prod_r[2*HALF_W-1:0], (HALF_W+1)'(0)});
            4'd3: begin
              rem_r   <= REM_W'(msq_fin[SQ_W-1:QUO_W-6]);
              nlo_r   <= {msq_fin[QUO_W-7:0], 6'b0};
              quo_r   <= '0;
              dcnt_r  <= '0;
              state_r <= ST_DIV;
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          rem_r  <= rem_n;
          quo_r  <= quo_n;
          nlo_r  <= {nlo_r[QUO_W-2:0], 1'b0};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCNT_W'(QUO_W - 1)) begin
            if (div_key < best_r[pt_r]) begin
              best_r[pt_r] <= div_key;
            end
            state_r <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          step_r <= '0;
          if (pt_r != 2'd2) begin
            pt_r    <= pt_r + 1'b1;
            state_r <= ST_DIST;
          end else if (CNT_W'(idx_r + 1'b1) == job_r.prev_cnt) begin
            state_r <= ST_CLASS;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_READ;
          end
        end
        ST_CLASS: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            4'd1: aa_r <= prod_r;
            4'd2: tt_r <= prod_r;
            4'd3: hh_r <= prod_r;
            4'd5: begin
              bb_r    <= prod_r;
              state_r <= ST_DONE;
            end
            default: ;
          endcase
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            ev_r        <= ev_c;
            br_r        <= br_c;
            sev_r       <= sev_c;
            dsq_r       <= dsq_c;
            height_r    <= height_c;
            tag_r       <= job_r.tag;
            full_r      <= job_r.full;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_event     = ev_r;
  assign out_is_bridge    = br_r;
  assign out_severity     = sev_r;
  assign out_max_dist_sq  = dsq_r;
  assign out_layer_height = height_r;
  assign out_tag_out      = tag_r;
  assign out_store_full   = full_r;

endmodule

FILE: src/lovc_checker.sv
// Port-level checks of the layer overhang classifier and their binding to the top level.
module lovc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_is_event,
  input logic                         out_is_bridge,
  input logic [lovc_pkg::SEV_W-1:0]   out_severity,
  input logic [lovc_pkg::Z_W-1:0]     out_layer_height,
  input logic [lovc_pkg::TAG_W-1:0]   out_tag_out
);
  import lovc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tag_out))
    else $error("A waiting result item changed or vanished.");

  a_quiet_non_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_event |-> !out_is_bridge && (out_severity == SEV_MINOR))
    else $error("A non-event item carries bridge or severity.");

  a_sev_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_severity == SEV_MINOR) || (out_severity == SEV_MODERATE) ||
                  (out_severity == SEV_SEVERE))
    else $error("Severity holds an unused code.");

  a_event_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_event |-> (out_layer_height != '0))
    else $error("An event item has no layer height.");

endmodule

bind layer_overhang_classifier lovc_checker u_lovc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_is_event     (out_is_event),
  .out_is_bridge    (out_is_bridge),
  .out_severity     (out_severity),
  .out_layer_height (out_layer_height),
  .out_tag_out      (out_tag_out)
);
